FILE: design/rsl_pkg.sv
// Shared constants, types and control bundles of the run-slice line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package rsl_pkg;

   // Tile coordinate width; the tile is 2^COORD_WIDTH pixels per side
   localparam int COORD_WIDTH = 6;
   // Run lengths, pixel counts and divider operands hold up to 2^COORD_WIDTH
   localparam int LEN_WIDTH   = COORD_WIDTH + 1;
   // Divider step counter counts LEN_WIDTH-1 down to zero
   localparam int STEP_WIDTH  = $clog2(LEN_WIDTH);

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_WIDTH = ((4 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [LEN_WIDTH-1:0]   len_type;
   typedef logic [STEP_WIDTH-1:0]  step_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;        // segment transfer accepted: set up endpoints and divider
      logic div_step;    // one restoring division step
      logic start_runs;  // take quotient and remainder, open the first run
      logic emit_xfer;   // pixel transfer done: advance to the next pixel
   } rsl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_done;    // the current division step is the final one
      logic last_pixel;  // the pixel on display is the segment's last
   } rsl_status_type;

endpackage
`default_nettype wire

FILE: design/run_slice_line_rasterizer.sv
// Top level of the run-slice line rasterizer: stream ports and payload packing.
//
// Usage: one segment enters on the req_ stream as two endpoints in the tile;
// the block returns every pixel of the segment on the rsp_ stream in drawing
// order (toward larger x), with rsp_tlast on the final pixel.
// Sequence: after a segment transfer, the serial run-length divider runs,
// a setup state then opens the first run, and the first pixel is offered
// on the rsp_ stream. Pixels then follow at one per cycle while
// rsp_tready is high.
// Segments: one at a time; the block takes no new segment while the serial
// divider or the single pixel stepper is busy with the previous one. req_tready
// is high only when the previous segment's last pixel has been transferred.
// Reset: synchronous, active high; returns to idle and drops any segment in
// progress. When the receiver stalls, the offered pixel holds and stepping
// pauses until the transfer completes.
`timescale 1ns / 1ps
`default_nettype none
module run_slice_line_rasterizer
   import rsl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // x_start, y_start, x_end, y_end from bit 0 up, zero padded
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // pixel_x, pixel_y from bit 0 up, zero padded
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic                           rsp_tlast
);

   rsl_cmd_type    cmd;
   rsl_status_type status;
   coord_type      pixel_x, pixel_y;

   rsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rsl_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .x_start (req_tdata[COORD_WIDTH-1:0]),
      .y_start (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .x_end   (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .y_end   (req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
      .pixel_x (pixel_x),
      .pixel_y (pixel_y),
      .is_last (rsp_tlast)
   );

   // Pack the pixel payload
   always_comb begin
      rsp_tdata                                = '0;
      rsp_tdata[COORD_WIDTH-1:0]               = pixel_x;
      rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH]   = pixel_y;
   end

endmodule
`default_nettype wire

FILE: design/rsl_datapath.sv
// Datapath: endpoint setup, serial run-length divider and pixel stepper.
`timescale 1ns / 1ps
`default_nettype none
module rsl_datapath
   import rsl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire rsl_cmd_type    cmd,
   output rsl_status_type      status,
   input  wire coord_type      x_start,
   input  wire coord_type      y_start,
   input  wire coord_type      x_end,
   input  wire coord_type      y_end,
   output coord_type           pixel_x,
   output coord_type           pixel_y,
   output logic                is_last
);

   // Endpoint setup, ordered toward larger x
   coord_type x0, y0, x1, y1, dx, ady, minor, major;
   logic      swap, y_down, x_major;

   // Registers
   coord_type cx_ff, cx_in, cy_ff, cy_in;
   logic      x_major_ff, x_major_in, y_down_ff, y_down_in;
   len_type   nruns_ff, nruns_in;
   len_type   quo_ff, quo_in;
   len_type   div_rem_ff, div_rem_in;
   step_type  step_ff, step_in;
   len_type   acc_ff, acc_in;
   len_type   run_left_ff, run_left_in;
   len_type   pix_left_ff, pix_left_in;

   // Divider step and run bookkeeping
   len_type   shifted, acc_sum, next_len;
   logic      fits, wrap, run_end;
   coord_type y_stepped;

   // Order endpoints and classify the slope
   always_comb begin
      swap    = x_start > x_end;
      x0      = swap ? x_end   : x_start;
      y0      = swap ? y_end   : y_start;
      x1      = swap ? x_start : x_end;
      y1      = swap ? y_start : y_end;
      dx      = x1 - x0;
      y_down  = y1 < y0;
      ady     = y_down ? (y0 - y1) : (y1 - y0);
      x_major = dx > ady;
      minor   = x_major ? ady : dx;
      major   = x_major ? dx  : ady;
   end

   // Restoring division: one quotient bit per step
   always_comb begin
      shifted = {div_rem_ff[LEN_WIDTH-2:0], quo_ff[LEN_WIDTH-1]};
      fits    = shifted >= nruns_ff;
   end

   // Next run length: one extra pixel when the remainder accumulator wraps
   always_comb begin
      acc_sum  = acc_ff + div_rem_ff;
      wrap     = acc_sum >= nruns_ff;
      next_len = quo_ff + LEN_WIDTH'(wrap);
      run_end  = run_left_ff == LEN_WIDTH'(1);
      y_stepped = y_down_ff ? (cy_ff - COORD_WIDTH'(1)) : (cy_ff + COORD_WIDTH'(1));
   end

   // Next-state selection
   always_comb begin
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      x_major_in  = x_major_ff;
      y_down_in   = y_down_ff;
      nruns_in    = nruns_ff;
      quo_in      = quo_ff;
      div_rem_in  = div_rem_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      run_left_in = run_left_ff;
      pix_left_in = pix_left_ff;
      if (cmd.load) begin
         cx_in       = x0;
         cy_in       = y0;
         x_major_in  = x_major;
         y_down_in   = y_down;
         nruns_in    = {1'b0, minor} + LEN_WIDTH'(1);
         quo_in      = {1'b0, major} + LEN_WIDTH'(1);
         pix_left_in = {1'b0, major} + LEN_WIDTH'(1);
         div_rem_in  = '0;
         step_in     = STEP_WIDTH'(LEN_WIDTH - 1);
      end
      if (cmd.div_step) begin
         div_rem_in = fits ? (shifted - nruns_ff) : shifted;
         quo_in     = {quo_ff[LEN_WIDTH-2:0], fits};
         step_in    = step_ff - STEP_WIDTH'(1);
      end
      // First run never carries the extra pixel; accumulator starts at rem
      if (cmd.start_runs) begin
         run_left_in = quo_ff;
         acc_in      = div_rem_ff;
      end
      // Step the major axis on every pixel, the minor axis at a run's end
      if (cmd.emit_xfer) begin
         pix_left_in = pix_left_ff - LEN_WIDTH'(1);
         if (x_major_ff || run_end) begin
            cx_in = cx_ff + COORD_WIDTH'(1);
         end
         if (!x_major_ff || run_end) begin
            cy_in = y_stepped;
         end
         if (run_end) begin
            run_left_in = next_len;
            acc_in      = wrap ? (acc_sum - nruns_ff) : acc_sum;
         end else begin
            run_left_in = run_left_ff - LEN_WIDTH'(1);
         end
      end
   end

   // Payload and working registers, no reset needed
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_major_ff  <= x_major_in;
      y_down_ff   <= y_down_in;
      nruns_ff    <= nruns_in;
      quo_ff      <= quo_in;
      div_rem_ff  <= div_rem_in;
      acc_ff      <= acc_in;
      run_left_ff <= run_left_in;
      pix_left_ff <= pix_left_in;
   end

   // Step counter is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // Status and pixel outputs
   always_comb begin
      status.div_done   = step_ff == '0;
      status.last_pixel = pix_left_ff == LEN_WIDTH'(1);
      pixel_x           = cx_ff;
      pixel_y           = cy_ff;
      is_last           = pix_left_ff == LEN_WIDTH'(1);
   end

endmodule
`default_nettype wire

FILE: design/rsl_ctrl.sv
// Controller: sequences segment setup, division and pixel emission.
`timescale 1ns / 1ps
`default_nettype none
module rsl_ctrl
   import rsl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire rsl_status_type status,
   output rsl_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RUN0 = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // Handshakes and commands
   always_comb begin
      req_tready     = state_ff == ST_IDLE;
      rsp_tvalid     = state_ff == ST_EMIT;
      cmd.load       = req_tready && req_tvalid;
      cmd.div_step   = state_ff == ST_DIV;
      cmd.start_runs = state_ff == ST_RUN0;
      cmd.emit_xfer  = rsp_tvalid && rsp_tready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_RUN0;
            end
         end
         ST_RUN0: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire
